// ===== hw/rtl/mcbd_pkg.sv =====
`default_nettype none

package mcbd_pkg;

    localparam int CountW  = 8;
    localparam int GapW    = 16;
    localparam int ClicksW = 4;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;

    localparam logic [CountW-1:0]  CountMax  = '1;
    localparam logic [GapW-1:0]    GapMax    = '1;
    localparam logic [ClicksW-1:0] ClicksMax = '1;

    // Register indexes on the configuration channel
    localparam logic [CfgIdxW-1:0] RegSampleInterval = 3'd0;
    localparam logic [CfgIdxW-1:0] RegLongPressLimit = 3'd1;
    localparam logic [CfgIdxW-1:0] RegReleaseSamples = 3'd2;
    localparam logic [CfgIdxW-1:0] RegMinPressSamples = 3'd3;
    localparam logic [CfgIdxW-1:0] RegGapTicks       = 3'd4;

    localparam logic [CountW-1:0] RstSampleInterval  = 8'd10;
    localparam logic [CountW-1:0] RstLongPressLimit  = 8'd20;
    localparam logic [CountW-1:0] RstReleaseSamples  = 8'd3;
    localparam logic [CountW-1:0] RstMinPressSamples = 8'd1;
    localparam logic [GapW-1:0]   RstGapTicks        = 16'd500;

    typedef struct packed {
        logic [CountW-1:0] sample_interval;
        logic [CountW-1:0] long_press_limit;
        logic [CountW-1:0] release_samples;
        logic [CountW-1:0] min_press_samples;
        logic [GapW-1:0]   gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic [ClicksW-1:0] click_count;
        logic               clicks_done;
        logic               long_press;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mcbd_cfg.sv =====
`default_nettype none

module mcbd_cfg
    import mcbd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_interval   <= RstSampleInterval;
            cfg_reg.long_press_limit  <= RstLongPressLimit;
            cfg_reg.release_samples   <= RstReleaseSamples;
            cfg_reg.min_press_samples <= RstMinPressSamples;
            cfg_reg.gap_ticks         <= RstGapTicks;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                RegSampleInterval: begin
                    cfg_reg.sample_interval <= cfg_data[CountW-1:0];
                end
                RegLongPressLimit: begin
                    cfg_reg.long_press_limit <= cfg_data[CountW-1:0];
                end
                RegReleaseSamples: begin
                    cfg_reg.release_samples <= cfg_data[CountW-1:0];
                end
                RegMinPressSamples: begin
                    cfg_reg.min_press_samples <= cfg_data[CountW-1:0];
                end
                RegGapTicks: begin
                    cfg_reg.gap_ticks <= cfg_data[GapW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mcbd_core.sv =====
`default_nettype none

module mcbd_core
    import mcbd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step_en,
    input  wire logic  button_level,
    input  wire cfg_t  cfg,
    output result_t    result
);

    logic [CountW-1:0]  prescale_reg, prescale_next;
    logic [CountW-1:0]  held_reg, held_next;
    logic [CountW-1:0]  released_reg, released_next;
    logic [ClicksW-1:0] pending_reg, pending_next;
    logic [GapW-1:0]    ticks_reg, ticks_next;

    logic [CountW-1:0]  pre1, held1, held2, rel1;
    logic [ClicksW-1:0] pend1;
    logic [GapW-1:0]    ticks1, ticks2;
    logic               sample, long_press, click, done;

    always_comb begin
        pre1   = (prescale_reg == CountMax) ? CountMax : prescale_reg + 1'b1;
        ticks1 = (ticks_reg == GapMax) ? GapMax : ticks_reg + 1'b1;
        sample = pre1 > cfg.sample_interval;

        held1 = held_reg;
        rel1  = released_reg;
        if (sample) begin
            if (!button_level) begin
                held1 = (held_reg == CountMax) ? CountMax : held_reg + 1'b1;
                rel1  = '0;
            end else begin
                rel1 = (released_reg == CountMax) ? CountMax : released_reg + 1'b1;
            end
        end

        // The held count is cleared on a long press, so the flag repeats while held.
        long_press = held1 > cfg.long_press_limit;
        held2      = long_press ? '0 : held1;

        click  = (rel1 > cfg.release_samples) && (held2 > cfg.min_press_samples);
        pend1  = pending_reg;
        ticks2 = ticks1;
        if (click) begin
            pend1  = (pending_reg == ClicksMax) ? ClicksMax : pending_reg + 1'b1;
            ticks2 = '0;
        end

        done = (pend1 != '0) && (ticks2 > cfg.gap_ticks);

        prescale_next = (sample || click || done) ? '0 : pre1;
        held_next     = (click || done) ? '0 : held2;
        released_next = (click || done) ? '0 : rel1;
        pending_next  = done ? '0 : pend1;
        ticks_next    = ticks2;

        result.long_press  = long_press;
        result.clicks_done = done;
        result.click_count = done ? pend1 : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            held_reg     <= '0;
            released_reg <= '0;
            pending_reg  <= '0;
            ticks_reg    <= '0;
        end else if (step_en) begin
            prescale_reg <= prescale_next;
            held_reg     <= held_next;
            released_reg <= released_next;
            pending_reg  <= pending_next;
            ticks_reg    <= ticks_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mcbd_out_reg.sv =====
`default_nettype none

module mcbd_out_reg
    import mcbd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire result_t    result_in,
    output logic            can_load,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output result_t         m_result
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // A new word may enter when the register is empty or is being emptied now.
    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/multi_click_button_detector.sv =====
// Multi-click button detector.
// Input stream: one word per timer tick; s_tdata[0] is the raw button level
// (0 = pressed). Output stream: one word per input word, carrying long_press,
// clicks_done and click_count. Thresholds are set through the cfg_* write
// channel (index 0 sample interval, 1 long press limit, 2 release samples,
// 3 minimum press samples, 4 gap ticks); cfg_ready is always high and writes
// should be made while no word is in flight.
// The result word is registered: it appears on m_tvalid in the cycle after the input
// word is taken. Throughput: one word per cycle while the receiver keeps up, set by
// the single pass through the counter update logic into the output register.
// Reset (aresetn low, synchronous) clears all counters and the output valid flag
// and restores the default thresholds.
// When the receiver stalls, the result stays in the output register and
// s_tready drops until it is taken; a word is accepted in the same cycle that
// the held result leaves.
`default_nettype none

module multi_click_button_detector
    import mcbd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [0] button_level, [7:1] zero
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,   // [0] long_press, [1] clicks_done,
                                                // [5:2] click_count, [7:6] zero
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    cfg_t    cfg;
    result_t core_result;
    result_t out_result;
    logic    s_accept;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    mcbd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mcbd_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (s_accept),
        .button_level (s_tdata[0]),
        .cfg          (cfg),
        .result       (core_result)
    );

    mcbd_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_accept),
        .result_in (core_result),
        .can_load  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (out_result)
    );

    assign m_tdata = {2'b00, out_result.click_count, out_result.clicks_done,
                      out_result.long_press};

    // A count is reported only with a completed sequence, and never as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1] == (m_tdata[5:2] != 4'd0)))
        else $error("click_count and clicks_done disagree");

    // Every accepted tick yields a result word in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted word produced no result");

    // A stalled result blocks the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while result stalled");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

// ===== tb/sv/tb_multi_click_button_detector.sv =====
`timescale 1ns / 1ps

module tb_multi_click_button_detector;
    import mcbd_pkg::*;

    localparam int unsigned StallLimit = 1000;
    localparam int unsigned TargetTicks = 1850;
    localparam int unsigned RunCap = 200;

    typedef enum int unsigned {
        RdyAlways,
        RdyCoin,
        RdyRare
    } ready_mode_e;

    // Tracks the detector's counters and thresholds and predicts one output word per tick.
    class click_ledger;
        cfg_t               regs;
        logic [CountW-1:0]  prescale;
        logic [CountW-1:0]  held;
        logic [CountW-1:0]  released;
        logic [ClicksW-1:0] pending;
        logic [GapW-1:0]    quiet_ticks;
        result_t            predicted_ticks[$];
        int unsigned        errors;
        int unsigned        words_checked;
        int unsigned        sequences_seen;
        int unsigned        long_presses_seen;
        int unsigned        largest_count;

        function new();
            regs.sample_interval   = RstSampleInterval;
            regs.long_press_limit  = RstLongPressLimit;
            regs.release_samples   = RstReleaseSamples;
            regs.min_press_samples = RstMinPressSamples;
            regs.gap_ticks         = RstGapTicks;
            prescale = '0;
            held = '0;
            released = '0;
            pending = '0;
            quiet_ticks = '0;
            errors = 0;
            words_checked = 0;
            sequences_seen = 0;
            long_presses_seen = 0;
            largest_count = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                RegSampleInterval:  regs.sample_interval   = data[CountW-1:0];
                RegLongPressLimit:  regs.long_press_limit  = data[CountW-1:0];
                RegReleaseSamples:  regs.release_samples   = data[CountW-1:0];
                RegMinPressSamples: regs.min_press_samples = data[CountW-1:0];
                RegGapTicks:        regs.gap_ticks         = data[GapW-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic level);
            result_t r;
            r = '0;
            if (prescale != CountMax) prescale = prescale + 1'b1;
            if (quiet_ticks != GapMax) quiet_ticks = quiet_ticks + 1'b1;

            if (prescale > regs.sample_interval) begin
                prescale = '0;
                if (!level) begin
                    if (held != CountMax) held = held + 1'b1;
                    released = '0;
                end else if (released != CountMax) begin
                    released = released + 1'b1;
                end
            end

            if (held > regs.long_press_limit) begin
                r.long_press = 1'b1;
                held = '0;
            end

            if (released > regs.release_samples && held > regs.min_press_samples) begin
                if (pending != ClicksMax) pending = pending + 1'b1;
                quiet_ticks = '0;
                held = '0;
                released = '0;
                prescale = '0;
            end

            if (pending != '0 && quiet_ticks > regs.gap_ticks) begin
                r.clicks_done = 1'b1;
                r.click_count = pending;
                held = '0;
                released = '0;
                prescale = '0;
                pending = '0;
            end
            predicted_ticks.push_back(r);
        endfunction

        function void check_word(logic [7:0] word);
            result_t want;
            if (predicted_ticks.size() == 0) begin
                $error("unexpected output word %h with no tick outstanding", word);
                errors++;
                return;
            end
            want = predicted_ticks.pop_front();
            words_checked++;
            if (word[0] !== want.long_press) begin
                $error("long_press: expected %0d, got %0d", want.long_press, word[0]);
                errors++;
            end
            if (word[1] !== want.clicks_done) begin
                $error("clicks_done: expected %0d, got %0d", want.clicks_done, word[1]);
                errors++;
            end
            if (word[5:2] !== want.click_count) begin
                $error("click_count: expected %0d, got %0d", want.click_count, word[5:2]);
                errors++;
            end
            if (word[7:6] !== 2'b00) begin
                $error("padding: expected 0, got %0d", word[7:6]);
                errors++;
            end
            if (want.long_press) long_presses_seen++;
            if (want.clicks_done) begin
                sequences_seen++;
                if (want.click_count > largest_count) largest_count = want.click_count;
            end
        endfunction

        function int unsigned outstanding();
            return predicted_ticks.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    click_ledger  board;
    int unsigned  ticks_sent = 0;
    int unsigned  burst_left = 0;
    int unsigned  settings_used = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  stretch_left = 0;
    int unsigned  hold_left = 0;
    bit           long_hold_done = 1'b0;
    ready_mode_e  ready_mode = RdyAlways;

    always #1 aclk = ~aclk;

    multi_click_button_detector u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Input ticks are noted before the output word is checked, so a same-edge pair stays in order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_tick(s_tdata[0]);
            if (m_tvalid && m_tready) board.check_word(m_tdata);
        end
    end

    // Receiver: stretches of steady, patchy or sparse readiness, plus one long hold-off
    // so that the output register fills and the input side backs up.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!long_hold_done && aresetn && board.words_checked >= 500) begin
            long_hold_done <= 1'b1;
            hold_left <= 64;
            m_tready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                ready_mode <= ready_mode_e'($urandom_range(0, 2));
                stretch_left <= $urandom_range(5, 40);
            end else begin
                stretch_left <= stretch_left - 1;
            end
            case (ready_mode)
                RdyAlways: m_tready <= 1'b1;
                RdyCoin:   m_tready <= ($urandom_range(0, 1) == 1);
                default:   m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("FAIL multi_click_button_detector");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_tick(logic level);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, level};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
    endtask

    task automatic send_run(logic level, int unsigned n);
        repeat (n) send_tick(level);
    endtask

    function automatic int unsigned cap_run(int unsigned n);
        return (n > RunCap) ? RunCap : n;
    endfunction

    // Mostly whole press/release cycles timed from the current thresholds, some long
    // holds, and short bursts of bounce.
    task automatic play_presses(int unsigned n_ticks);
        int unsigned target;
        int unsigned unit;
        int unsigned roll;
        target = ticks_sent + n_ticks;
        while (ticks_sent < target) begin
            unit = board.regs.sample_interval + 1;
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                send_run(1'b0, cap_run(unit * (board.regs.min_press_samples
                                               + $urandom_range(1, 3))));
                send_run(1'b1, cap_run(unit * (board.regs.release_samples
                                               + $urandom_range(1, 3))));
                if ($urandom_range(0, 3) == 0)
                    send_run(1'b1, cap_run(board.regs.gap_ticks + $urandom_range(1, 8)));
            end else if (roll < 82) begin
                send_run(1'b0, cap_run(unit * (board.regs.long_press_limit
                                               + $urandom_range(1, 4))));
            end else begin
                repeat ($urandom_range(1, 12))
                    send_run(1'($urandom_range(0, 1)), $urandom_range(1, 3));
            end
        end
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.write_reg(idx, data);
    endtask

    // The upper byte of the data written to the 8-bit registers carries noise; only the low byte may count.
    task automatic apply_settings(logic [CountW-1:0] interval, logic [CountW-1:0] long_limit,
                                  logic [CountW-1:0] release_need,
                                  logic [CountW-1:0] press_need,
                                  logic [GapW-1:0] gap, bit with_unused);
        if (with_unused) begin
            for (int i = RegGapTicks + 1; i < (1 << CfgIdxW); i++)
                write_reg(CfgIdxW'(i), CfgDataW'($urandom));
        end
        write_reg(RegSampleInterval,  {8'($urandom), interval});
        write_reg(RegLongPressLimit,  {8'($urandom), long_limit});
        write_reg(RegReleaseSamples,  {8'($urandom), release_need});
        write_reg(RegMinPressSamples, {8'($urandom), press_need});
        write_reg(RegGapTicks,        gap);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    initial begin
        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default thresholds: one held sample then a release.
        send_run(1'b0, 12);
        send_run(1'b1, 12);
        wait_drained();

        // Sample every tick: more clicks than the count can hold, then a release long
        // enough to pin the released count, then a hold long enough to pin the held count.
        apply_settings(8'd0, CountMax, 8'd0, 8'd0, 16'd255, 1'b1);
        repeat (20) begin
            send_tick(1'b0);
            send_tick(1'b1);
        end
        send_run(1'b1, 260);
        send_run(1'b0, 260);
        send_run(1'b1, 4);
        wait_drained();

        // Every threshold at its top: the prescaler pins and nothing is ever sampled.
        apply_settings(CountMax, CountMax, CountMax, CountMax, GapMax, 1'b0);
        play_presses(300);
        wait_drained();

        apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 1'b0);
        play_presses(150);
        wait_drained();

        while (ticks_sent < TargetTicks) begin
            apply_settings(($urandom_range(0, 7) == 0) ? 8'($urandom_range(4, 20))
                                                       : 8'($urandom_range(0, 3)),
                           8'($urandom_range(0, 12)), 8'($urandom_range(0, 4)),
                           8'($urandom_range(0, 4)),
                           ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 60)),
                           1'b0);
            play_presses(120);
            wait_drained();
        end

        repeat (4) @(posedge aclk);
        if (board.outstanding() != 0) begin
            $error("%0d predicted output words never arrived", board.outstanding());
            board.errors++;
        end
        $display("Drove %0d ticks under %0d threshold settings.", ticks_sent, settings_used);
        $display("Saw %0d completed click sequences (largest count %0d) and %0d long presses.",
                 board.sequences_seen, board.largest_count, board.long_presses_seen);
        if (board.errors == 0) begin
            $display("PASS multi_click_button_detector");
        end else begin
            $display("FAIL multi_click_button_detector");
        end
        $finish;
    end

endmodule
